[sv/indexed_array_list_defines.svh]
// Assertion macros shared by the indexed_array_list checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef INDEXED_ARRAY_LIST_DEFINES_SVH
`define INDEXED_ARRAY_LIST_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define IAL_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IAL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ial_pkg.sv]
// Package for indexed_array_list: sizes, codes, state and command types.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package ial_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int MODE_W      = 3;
    localparam int POS_W       = 7;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int FPOS_W      = 6;
    localparam int LEN_W       = 7;
    localparam int CMP_W       = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 3'd0,
        MODE_FIND   = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_ERASE  = 3'd3,
        MODE_CLEAR  = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GET_RD,
        S_GET_CAP,
        S_FIND_RD,
        S_FIND_CMP,
        S_INS_RD,
        S_INS_MV,
        S_INS_WR,
        S_ERA_RD,
        S_ERA_MV,
        S_ERA_END,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        RD_POS,
        RD_IDX,
        RD_IDX_DEC,
        RD_IDX_INC
    } t_rd_sel;

    typedef enum logic {
        WR_SHIFT,
        WR_VALUE
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_POS,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        logic    set_status;
        t_status status;
        logic    cap_read;
        logic    cap_found;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  pos_ge_cnt;
        logic  pos_gt_cnt;
        logic  full;
        logic  cnt_zero;
        logic  cnt_eq_pos;
        logic  era_single;
        logic  ins_at_pos;
        logic  match;
        logic  find_last;
        logic  era_last;
        logic  out_free;
    } t_dp_sts;

endpackage

[sv/ial_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; instantiated by the indexed_array_list datapath.
`timescale 1ns / 1ps

module ial_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/ial_ctrl.sv]
// Controller state machine for indexed_array_list: sequences each request.
// Depends on ial_pkg; drives the datapath through t_dp_cmd, reads t_dp_sts.
`timescale 1ns / 1ps

module ial_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ial_pkg::t_dp_sts i_sts,
    output ial_pkg::t_dp_cmd o_cmd
);
    import ial_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.mode)
                    MODE_GET: begin
                        if (i_sts.pos_ge_cnt) begin
                            w_cmd.set_status = 1'b1;
                            w_cmd.status     = ST_BADPOS;
                            n_state          = S_RESP;
                        end else begin
                            n_state = S_GET_RD;
                        end
                    end
                    MODE_FIND: begin
                        w_cmd.idx_op = IDX_ZERO;
                        if (i_sts.cnt_zero) begin
                            w_cmd.set_status = 1'b1;
                            w_cmd.status     = ST_NOTFOUND;
                            n_state          = S_RESP;
                        end else begin
                            n_state = S_FIND_RD;
                        end
                    end
                    MODE_INSERT: begin
                        w_cmd.idx_op = IDX_COUNT;
                        if (i_sts.pos_gt_cnt) begin
                            w_cmd.set_status = 1'b1;
                            w_cmd.status     = ST_BADPOS;
                            n_state          = S_RESP;
                        end else if (i_sts.full) begin
                            w_cmd.set_status = 1'b1;
                            w_cmd.status     = ST_FULL;
                            n_state          = S_RESP;
                        end else if (i_sts.cnt_eq_pos) begin
                            n_state = S_INS_WR;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    MODE_ERASE: begin
                        w_cmd.idx_op = IDX_POS;
                        if (i_sts.pos_ge_cnt) begin
                            w_cmd.set_status = 1'b1;
                            w_cmd.status     = ST_BADPOS;
                            n_state          = S_RESP;
                        end else if (i_sts.era_single) begin
                            n_state = S_ERA_END;
                        end else begin
                            n_state = S_ERA_RD;
                        end
                    end
                    MODE_CLEAR: begin
                        w_cmd.cnt_op = CNT_CLEAR;
                        n_state      = S_RESP;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_GET_RD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_POS;
                n_state      = S_GET_CAP;
            end
            S_GET_CAP: begin
                w_cmd.cap_read = 1'b1;
                n_state        = S_RESP;
            end
            S_FIND_RD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_IDX;
                n_state      = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (i_sts.match) begin
                    w_cmd.cap_found = 1'b1;
                    n_state         = S_RESP;
                end else if (i_sts.find_last) begin
                    w_cmd.set_status = 1'b1;
                    w_cmd.status     = ST_NOTFOUND;
                    n_state          = S_RESP;
                end else begin
                    w_cmd.idx_op = IDX_INC;
                    n_state      = S_FIND_RD;
                end
            end
            S_INS_RD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_IDX_DEC;
                n_state      = S_INS_MV;
            end
            S_INS_MV: begin
                w_cmd.wr_en  = 1'b1;
                w_cmd.wr_sel = WR_SHIFT;
                w_cmd.idx_op = IDX_DEC;
                n_state      = i_sts.ins_at_pos ? S_INS_WR : S_INS_RD;
            end
            S_INS_WR: begin
                w_cmd.wr_en  = 1'b1;
                w_cmd.wr_sel = WR_VALUE;
                w_cmd.cnt_op = CNT_INC;
                n_state      = S_RESP;
            end
            S_ERA_RD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_IDX_INC;
                n_state      = S_ERA_MV;
            end
            S_ERA_MV: begin
                w_cmd.wr_en  = 1'b1;
                w_cmd.wr_sel = WR_SHIFT;
                w_cmd.idx_op = IDX_INC;
                n_state      = i_sts.era_last ? S_ERA_END : S_ERA_RD;
            end
            S_ERA_END: begin
                w_cmd.cnt_op = CNT_DEC;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

[sv/ial_dp.sv]
// Datapath for indexed_array_list: request, count, index, result and output registers.
// Depends on ial_pkg and ial_ram; obeys t_dp_cmd and reports t_dp_sts.
`timescale 1ns / 1ps

module ial_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ial_pkg::t_dp_cmd               i_cmd,
    output ial_pkg::t_dp_sts               o_sts,
    input  ial_pkg::t_mode                 i_req_mode,
    input  logic [ial_pkg::POS_W-1:0]      i_req_pos,
    input  logic [ial_pkg::VALUE_W-1:0]    i_req_value,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output ial_pkg::t_status               o_out_status,
    output logic [ial_pkg::VALUE_W-1:0]    o_out_read_value,
    output logic [ial_pkg::FPOS_W-1:0]     o_out_found,
    output logic [ial_pkg::LEN_W-1:0]      o_out_length
);
    import ial_pkg::*;

    t_mode                 r_mode;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_value;
    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_idx;
    t_status               r_status;
    logic [DATA_WIDTH-1:0] r_read;
    logic [ADDR_W-1:0]     r_found;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [VALUE_W-1:0]    r_out_read_value;
    logic [FPOS_W-1:0]     r_out_found;
    logic [LEN_W-1:0]      r_out_length;

    logic [ADDR_W-1:0]     w_rd_addr;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_cnt_x;
    logic [CMP_W-1:0]      w_idx_x;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_POS:     w_rd_addr = ADDR_W'(r_pos);
            RD_IDX:     w_rd_addr = r_idx;
            RD_IDX_DEC: w_rd_addr = r_idx - ADDR_W'(1);
            RD_IDX_INC: w_rd_addr = r_idx + ADDR_W'(1);
            default:    w_rd_addr = r_idx;
        endcase
    end

    assign w_wr_addr = (i_cmd.wr_sel == WR_VALUE) ? ADDR_W'(r_pos) : r_idx;
    assign w_wr_data = (i_cmd.wr_sel == WR_VALUE) ? r_value : w_rd_data;

    ial_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode  <= i_req_mode;
            r_pos   <= i_req_pos;
            r_value <= DATA_WIDTH'(i_req_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_CLEAR: r_count <= '0;
                CNT_INC:   r_count <= r_count + CNT_W'(1);
                CNT_DEC:   r_count <= r_count - CNT_W'(1);
                default:   r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.idx_op)
            IDX_ZERO:  r_idx <= '0;
            IDX_COUNT: r_idx <= ADDR_W'(r_count);
            IDX_POS:   r_idx <= ADDR_W'(r_pos);
            IDX_INC:   r_idx <= r_idx + ADDR_W'(1);
            IDX_DEC:   r_idx <= r_idx - ADDR_W'(1);
            default:   r_idx <= r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_status <= ST_OK;
            r_read   <= '0;
            r_found  <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.cap_read) begin
                r_read <= w_rd_data;
            end
            if (i_cmd.cap_found) begin
                r_found <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status     <= r_status;
            r_out_read_value <= VALUE_W'(r_read);
            r_out_found      <= FPOS_W'(r_found);
            r_out_length     <= LEN_W'(r_count);
        end
    end

    assign w_pos_x = CMP_W'(r_pos);
    assign w_cnt_x = CMP_W'(r_count);
    assign w_idx_x = CMP_W'(r_idx);

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.pos_ge_cnt = (w_pos_x >= w_cnt_x);
        o_sts.pos_gt_cnt = (w_pos_x > w_cnt_x);
        o_sts.full       = (r_count == CNT_W'(CAPACITY));
        o_sts.cnt_zero   = (r_count == '0);
        o_sts.cnt_eq_pos = (w_pos_x == w_cnt_x);
        o_sts.era_single = ((w_pos_x + CMP_W'(1)) >= w_cnt_x);
        o_sts.ins_at_pos = (w_idx_x == (w_pos_x + CMP_W'(1)));
        o_sts.match      = (w_rd_data == r_value);
        o_sts.find_last  = ((w_idx_x + CMP_W'(1)) == w_cnt_x);
        o_sts.era_last   = ((w_idx_x + CMP_W'(2)) >= w_cnt_x);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_status     = r_out_status;
    assign o_out_read_value = r_out_read_value;
    assign o_out_found      = r_out_found;
    assign o_out_length     = r_out_length;

endmodule

[sv/indexed_array_list.sv]
// indexed_array_list: fixed-capacity ordered list of data words (top level).
// Depends on ial_pkg, ial_ctrl, ial_dp and ial_ram.
//
// Usage:
//   One request enters on the s_axis channel: mode (get, find, insert, erase,
//   clear), a list position and a data word. Exactly one result leaves on the
//   m_axis channel: status, the word read by get, the position found by find
//   and the list length after the request.
//   Requests are handled one at a time; o_s_axis_tready is high only while
//   the controller is idle. The list sits in a single-port-write RAM with
//   registered read, so each entry visited is read in a state of its own, and
//   entries shifted by insert or erase are written back in a separate state.
//   A new request is taken in the cycle after its result is loaded into the
//   output register.
//   Reset empties the list and drops any pending result; RAM contents are
//   left as they are and are never read before being written.
//   A stalled receiver holds the result in the output register; the next
//   request is still accepted and processed, and waits only to deliver.
`timescale 1ns / 1ps

module indexed_array_list (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // mode[2:0], position[9:3], value[41:10], zero fill
    input  logic [ial_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // status[1:0], read_value[33:2], found_position[39:34], length[46:40], zero fill
    output logic [ial_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import ial_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;
    t_mode              w_req_mode;
    logic [POS_W-1:0]   w_req_pos;
    logic [VALUE_W-1:0] w_req_value;
    t_status            w_out_status;
    logic [VALUE_W-1:0] w_out_read_value;
    logic [FPOS_W-1:0]  w_out_found;
    logic [LEN_W-1:0]   w_out_length;

    assign w_req_mode  = t_mode'(i_s_axis_tdata[MODE_W-1:0]);
    assign w_req_pos   = i_s_axis_tdata[MODE_W +: POS_W];
    assign w_req_value = i_s_axis_tdata[MODE_W + POS_W +: VALUE_W];

    ial_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ial_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_mode       (w_req_mode),
        .i_req_pos        (w_req_pos),
        .i_req_value      (w_req_value),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_out_status     (w_out_status),
        .o_out_read_value (w_out_read_value),
        .o_out_found      (w_out_found),
        .o_out_length     (w_out_length)
    );

    assign o_m_axis_tdata = {
        {(OUT_TDATA_W - LEN_W - FPOS_W - VALUE_W - STATUS_W){1'b0}},
        w_out_length,
        w_out_found,
        w_out_read_value,
        w_out_status
    };

endmodule

[sv/ial_checker.sv]
// Port-level checker for indexed_array_list, bound to the top level.
// Depends on ial_pkg and indexed_array_list_defines.svh.
`timescale 1ns / 1ps
`include "indexed_array_list_defines.svh"

module ial_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            i_s_tready,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [ial_pkg::OUT_TDATA_W-1:0] i_m_tdata
);
    import ial_pkg::*;

    logic [STATUS_W-1:0] w_status;
    logic [VALUE_W-1:0]  w_read_value;
    logic [FPOS_W-1:0]   w_found;
    logic [LEN_W-1:0]    w_length;

    assign w_status     = i_m_tdata[STATUS_W-1:0];
    assign w_read_value = i_m_tdata[STATUS_W +: VALUE_W];
    assign w_found      = i_m_tdata[STATUS_W + VALUE_W +: FPOS_W];
    assign w_length     = i_m_tdata[STATUS_W + VALUE_W + FPOS_W +: LEN_W];

    `IAL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "result dropped while stalled")
    `IAL_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready, "second request taken while busy")
    `IAL_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, i_m_tvalid, w_length <= LEN_W'(CAPACITY), "length above capacity")
    `IAL_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_m_tvalid && (w_status != ST_OK), (w_read_value == '0) && (w_found == '0), "error result carries data")

endmodule

bind indexed_array_list ial_checker u_ial_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

[tb/tb_indexed_array_list.sv]
// Self-checking testbench for indexed_array_list: directed list operations, then random
// fill, drain and mixed phases with random stalls on both stream sides.
// Depends on ial_pkg and the indexed_array_list RTL.
`timescale 1ns / 1ps

typedef struct packed {
    ial_pkg::t_status               status;
    logic [ial_pkg::VALUE_W-1:0]    read_value;
    logic [ial_pkg::FPOS_W-1:0]     found_pos;
    logic [ial_pkg::LEN_W-1:0]      length;
} list_result_t;

class list_scoreboard;
    logic [ial_pkg::DATA_WIDTH-1:0] words [ial_pkg::CAPACITY];
    int unsigned                    used;
    list_result_t                   pending [$];
    int                             errors;

    function new();
        used   = 0;
        errors = 0;
    endfunction

    task report(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function void note_request(logic [ial_pkg::MODE_W-1:0] mode,
                               logic [ial_pkg::POS_W-1:0] pos,
                               logic [ial_pkg::VALUE_W-1:0] value);
        list_result_t r;
        int           hit;
        r   = '0;
        hit = -1;
        case (mode)
            ial_pkg::MODE_GET: begin
                if (pos >= used) r.status = ial_pkg::ST_BADPOS;
                else r.read_value = words[pos];
            end
            ial_pkg::MODE_FIND: begin
                for (int k = 0; k < used; k++) begin
                    if (words[k] == value[ial_pkg::DATA_WIDTH-1:0]) begin
                        hit = k;
                        break;
                    end
                end
                if (hit < 0) r.status = ial_pkg::ST_NOTFOUND;
                else r.found_pos = hit[ial_pkg::FPOS_W-1:0];
            end
            ial_pkg::MODE_INSERT: begin
                if (pos > used) begin
                    r.status = ial_pkg::ST_BADPOS;
                end else if (used >= ial_pkg::CAPACITY) begin
                    r.status = ial_pkg::ST_FULL;
                end else begin
                    for (int k = used; k > pos; k--) words[k] = words[k-1];
                    words[pos] = value[ial_pkg::DATA_WIDTH-1:0];
                    used++;
                end
            end
            ial_pkg::MODE_ERASE: begin
                if (pos >= used) begin
                    r.status = ial_pkg::ST_BADPOS;
                end else begin
                    for (int k = pos; k + 1 < used; k++) words[k] = words[k+1];
                    used--;
                end
            end
            ial_pkg::MODE_CLEAR: used = 0;
            default: ;
        endcase
        r.length = used[ial_pkg::LEN_W-1:0];
        pending.push_back(r);
    endfunction

    task check_result(logic [ial_pkg::OUT_TDATA_W-1:0] word);
        list_result_t got;
        list_result_t want;
        got.status     = ial_pkg::t_status'(word[1:0]);
        got.read_value = word[33:2];
        got.found_pos  = word[39:34];
        got.length     = word[46:40];
        if (pending.size() == 0) begin
            report($sformatf("result %h with no request pending", word));
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.read_value !== want.read_value)
            report($sformatf("read_value %h, want %h", got.read_value, want.read_value));
        if (got.found_pos !== want.found_pos)
            report($sformatf("found_position %0d, want %0d", got.found_pos, want.found_pos));
        if (got.length !== want.length)
            report($sformatf("length %0d, want %0d", got.length, want.length));
    endtask
endclass

module tb_indexed_array_list;
    import ial_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_NOP_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 1150;
    localparam int TAIL_ITEMS   = 150;
    localparam int STALL_LIMIT  = 4000;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    bit             tx_idle_on = 1'b0;
    bit             rx_idle_on = 1'b0;
    int             rx_hold    = 0;
    int             quiet_cycles = 0;
    int             sent       = 0;
    list_scoreboard sb = new();

    indexed_array_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (rx_hold == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
            rx_hold = $urandom_range(1, 10);
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic issue(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                         input logic [VALUE_W-1:0] value);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - VALUE_W - POS_W - MODE_W){1'b0}}, value, pos, mode};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(mode, pos, value);
        sent++;
    endtask

    // hold requests until the list has answered everything
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] pick_pos(bit for_insert);
        int top;
        top = int'(sb.used) - (for_insert ? 0 : 1);
        if (top < 0 || $urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, POS_MAX));
        return POS_W'($urandom_range(0, top));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VALUE_W'($urandom_range(0, 7));
            3, 4: if (sb.used > 0) return sb.words[$urandom_range(0, sb.used - 1)];
            default: ;
        endcase
        return $urandom;
    endfunction

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)       issue(MODE_W'($urandom_range(MODE_NOP_FIRST, MODE_NOP_LAST)),
                               POS_W'($urandom), $urandom);
        else if (r < 5)  issue(MODE_CLEAR, POS_W'($urandom), $urandom);
        else if (r < 28) issue(MODE_GET, pick_pos(1'b0), $urandom);
        else if (r < 48) issue(MODE_FIND, POS_W'($urandom), pick_value());
        else if (r < 78) issue(MODE_INSERT, pick_pos(1'b1), pick_value());
        else             issue(MODE_ERASE, pick_pos(1'b0), $urandom);
    endtask

    initial begin
        int  first_random;
        int  phase;
        bit  tail;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        issue(MODE_GET, '0, '0);
        issue(MODE_ERASE, '0, '0);
        issue(MODE_FIND, '0, '0);
        issue(MODE_INSERT, 7'd1, 32'h1234_5678);
        issue(MODE_INSERT, POS_W'(POS_MAX), 32'h1234_5678);
        issue(MODE_INSERT, '0, '1);
        issue(MODE_INSERT, 7'd1, '0);
        issue(MODE_INSERT, 7'd1, 32'h8000_0001);
        issue(MODE_INSERT, '0, 32'h5555_AAAA);
        issue(MODE_INSERT, 7'd2, '0);
        issue(MODE_GET, '0, '0);
        issue(MODE_GET, 7'd4, '0);
        issue(MODE_GET, 7'd5, '0);
        issue(MODE_FIND, POS_W'(POS_MAX), '0);
        issue(MODE_FIND, '0, '1);
        issue(MODE_FIND, '0, 32'h1234_5678);
        issue(MODE_ERASE, 7'd4, '1);
        issue(MODE_ERASE, '0, '0);
        issue(MODE_ERASE, 7'd1, '0);
        issue(MODE_ERASE, 7'd2, '0);
        issue(MODE_NOP_FIRST, 7'd3, '1);
        issue(MODE_W'(MODE_NOP_FIRST + 1'b1), '0, '0);
        issue(MODE_NOP_LAST, POS_W'(POS_MAX), '1);
        issue(MODE_CLEAR, 7'd64, '1);
        issue(MODE_GET, '0, '0);

        first_random = sent;
        phase = 0;
        while (sent - first_random < RANDOM_ITEMS) begin
            tail       = (sent - first_random) >= RANDOM_ITEMS - TAIL_ITEMS;
            tx_idle_on = !tail && $urandom_range(0, 3) != 0;
            rx_idle_on = !tail && $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0, 1: begin
                    while (sb.used < CAPACITY) begin
                        if ($urandom_range(0, 4) == 0) issue(MODE_FIND, POS_W'($urandom),
                                                             pick_value());
                        else issue(MODE_INSERT, pick_pos(1'b1), pick_value());
                    end
                    repeat ($urandom_range(2, 4))
                        issue(MODE_INSERT, POS_W'($urandom_range(0, POS_MAX)), $urandom);
                    repeat (4) issue(MODE_GET, pick_pos(1'b0), $urandom);
                end
                2: begin
                    while (sb.used > 0) issue(MODE_ERASE, pick_pos(1'b0), $urandom);
                    issue(MODE_ERASE, '0, $urandom);
                end
                3: begin
                    issue(MODE_CLEAR, POS_W'($urandom), $urandom);
                    repeat ($urandom_range(3, 10)) random_request();
                end
                default: repeat ($urandom_range(20, 60)) random_request();
            endcase
            if (phase == 0 || $urandom_range(0, 4) == 0) drain_results();
            phase++;
        end

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
